FILE: hdl/sate_pkg.sv
`timescale 1ns / 1ps
package sate_pkg;

	localparam int SATE_DEPTH = 16;
	localparam int KEY_W      = 64;
	localparam int TAG_W      = 64;
	localparam int BYTES_W    = 48;
	localparam int SUM_W      = 52;
	localparam int AMT_W      = 16;
	localparam int QUO_W      = 15;

	localparam logic [AMT_W-1:0] AMOUNT_MIN = 16'd655;
	localparam logic [AMT_W-1:0] AMOUNT_MAX = 16'd32768;

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_UPDATE = 3'd2,
		CMD_LKKEY  = 3'd3,
		CMD_LKTAG  = 3'd4,
		CMD_LOWEST = 3'd5,
		CMD_TOTALS = 3'd6
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_e_t;

	// request fields broadcast to every cell
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TAG_W-1:0]   tag;
		logic               tpres;
		logic [BYTES_W-1:0] usage;
		logic [BYTES_W-1:0] alloc;
		logic [BYTES_W-1:0] score;
	} req_t;

	// write action broadcast to every cell
	typedef struct packed {
		logic               en;
		cmd_e_t             op;
		logic               any_hit;
		logic               ua_en;
		logic [TAG_W-1:0]   ua;
		logic               ub_en;
		logic [TAG_W-1:0]   ub;
		logic [BYTES_W-1:0] new_score;
	} apply_t;

	// record handed from cell to cell during a scan
	typedef struct packed {
		logic               pass;
		logic               key_hit;
		logic [TAG_W-1:0]   hit_tag;
		logic               hit_tp;
		logic [BYTES_W-1:0] hit_usage;
		logic [BYTES_W-1:0] hit_alloc;
		logic [BYTES_W-1:0] hit_score;
		logic               free_seen;
		logic               tag_found;
		logic [KEY_W-1:0]   tag_key;
		logic               min_valid;
		logic [BYTES_W-1:0] min_score;
		logic [KEY_W-1:0]   min_key;
	} rec_t;

endpackage

FILE: hdl/sate_cell.sv
`timescale 1ns / 1ps
module sate_cell import sate_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  req_t   req,
	input  apply_t wr,
	input  rec_t   rec_in,
	output rec_t   rec_out,
	output logic   key_here,
	output logic   free_here
);

	logic               valid_q;
	logic               mapped_q;
	logic               tp_q;
	logic [KEY_W-1:0]   key_q;
	logic [TAG_W-1:0]   tag_q;
	logic [BYTES_W-1:0] usage_q;
	logic [BYTES_W-1:0] alloc_q;
	logic [BYTES_W-1:0] score_q;
	logic               key_here_q;
	logic               free_here_q;
	rec_t               rec_q;
	rec_t               nxt;
	logic               match_key;
	logic               target;
	logic               unmap;

	assign match_key = valid_q && (key_q == req.key);

	always_comb begin
		nxt = rec_in;
		if (match_key && !rec_in.key_hit) begin
			nxt.key_hit   = 1'b1;
			nxt.hit_tag   = tag_q;
			nxt.hit_tp    = tp_q;
			nxt.hit_usage = usage_q;
			nxt.hit_alloc = alloc_q;
			nxt.hit_score = score_q;
		end
		if (!valid_q)
			nxt.free_seen = 1'b1;
		if (!rec_in.tag_found && valid_q && mapped_q && req.tpres && tag_q == req.tag) begin
			nxt.tag_found = 1'b1;
			nxt.tag_key   = key_q;
		end
		if (valid_q && (!rec_in.min_valid || score_q < rec_in.min_score ||
				(score_q == rec_in.min_score && key_q < rec_in.min_key))) begin
			nxt.min_valid = 1'b1;
			nxt.min_score = score_q;
			nxt.min_key   = key_q;
		end
	end

	assign target = key_here_q || (!wr.any_hit && free_here_q);
	assign unmap  = valid_q && mapped_q &&
		((wr.ua_en && tag_q == wr.ua) || (wr.ub_en && tag_q == wr.ub));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			mapped_q    <= 1'b0;
			key_here_q  <= 1'b0;
			free_here_q <= 1'b0;
			rec_q.pass  <= 1'b0;
		end else begin
			rec_q <= nxt;
			if (rec_in.pass) begin
				key_here_q  <= match_key;
				free_here_q <= !valid_q && !rec_in.free_seen;
			end
			if (wr.en) begin
				if (target) begin
					case (wr.op)
						CMD_ADD: begin
							valid_q  <= 1'b1;
							mapped_q <= req.tpres;
							tp_q     <= req.tpres;
							key_q    <= req.key;
							tag_q    <= req.tpres ? req.tag : '0;
							usage_q  <= req.usage;
							alloc_q  <= req.alloc;
							score_q  <= req.score;
						end
						CMD_REMOVE: begin
							valid_q  <= 1'b0;
							mapped_q <= 1'b0;
						end
						CMD_UPDATE: score_q <= wr.new_score;
						default: ;
					endcase
				end else if (unmap) begin
					mapped_q <= 1'b0;
				end
			end
		end
	end

	assign rec_out   = rec_q;
	assign key_here  = key_here_q;
	assign free_here = free_here_q;

endmodule

FILE: hdl/sate_div.sv
`timescale 1ns / 1ps
module sate_div import sate_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [BYTES_W-1:0] rem_init,
	input  logic [BYTES_W-1:0] divisor,
	output logic               done,
	output logic [QUO_W-1:0]   quo
);

	logic [BYTES_W-1:0] rem_q;
	logic [BYTES_W-1:0] div_q;
	logic [QUO_W-1:0]   quo_q;
	logic [3:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [BYTES_W:0]   sh;
	logic               ge;
	logic [BYTES_W:0]   diff;

	assign sh   = {rem_q, 1'b0};
	assign ge   = sh >= {1'b0, div_q};
	assign diff = sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= rem_init;
				div_q  <= divisor;
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? diff[BYTES_W-1:0] : sh[BYTES_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hdl/scored_asset_table_eviction_top.sv
`timescale 1ns / 1ps
// channel | dir | tdata                                   | tuser
// s_*     | in  | key, tag, usage, alloc, score, now      | command, tag_present
// m_*     | out | found_key, found_tag, score, usage_total, allocation_total | status, tag_present
// In each request a record walks the cell chain one cell per cycle.
// A score update adds the multiply and adjust states, and the S_DIV state when the ratio needs
// the divider. The block returns to idle between two requests.
// Reset clears the valid and tag-map bits of every cell and the totals; no clearing pass.
// A new request is taken in idle even while a result waits on m_*; finishing holds until
// the output register is free.
module scored_asset_table_eviction_top import sate_pkg::*; #(
	parameter int TABLE_DEPTH = SATE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [319:0] s_tdata,  // key 64, tag 64, usage 48, alloc 48, score 48, now 48
	input  logic [3:0]   s_tuser,  // command 3, tag_present 1
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [279:0] m_tdata,  // found_key 64, found_tag 64, score 48, usage 52, alloc 52
	output logic [2:0]   m_tuser   // status 2, found_tag_present 1
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_PREP, S_DIV, S_MUL, S_ADJ, S_FINISH
	} state_t;

	state_t             state_q;
	req_t               req_q;
	cmd_e_t             op_q;
	logic [BYTES_W-1:0] now_q;
	logic               start_q;
	rec_t               res_q;
	rec_t               chain [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TABLE_DEPTH-1:0] free_vec;
	apply_t             wr;
	logic [SUM_W-1:0]   usum_q;
	logic [SUM_W-1:0]   asum_q;
	logic [AMT_W-1:0]   amount_q;
	logic [63:0]        prod_s1;
	logic               up_s1;
	logic [BYTES_W-1:0] new_score_q;
	logic               out_free;
	logic               div_start;
	logic               div_done;
	logic [QUO_W-1:0]   div_quo;
	logic [BYTES_W-1:0] size;
	logic [BYTES_W-1:0] diff;
	logic [BYTES_W-1:0] gap;
	logic [AMT_W-1:0]   quo_amt;
	logic               do_write;
	logic [279:0]       out_data;
	logic [2:0]         out_user;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		chain[0]      = '0;
		chain[0].pass = start_q;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		sate_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (req_q),
			.wr       (wr),
			.rec_in   (chain[g]),
			.rec_out  (chain[g+1]),
			.key_here (hit_vec[g]),
			.free_here(free_vec[g])
		);
	end

	assign size = (req_q.usage == '0) ? res_q.hit_usage : req_q.usage;
	assign diff = res_q.hit_usage - size;
	assign div_start = (state_q == S_PREP) && op_q == CMD_UPDATE && res_q.key_hit &&
		size != '0 && !(size > res_q.hit_usage) &&
		!({diff, 1'b0} >= {1'b0, size});

	sate_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.rem_init({diff[BYTES_W-2:0], 1'b0}),
		.divisor (size),
		.done    (div_done),
		.quo     (div_quo)
	);

	assign quo_amt = {1'b0, div_quo};
	assign gap = (now_q >= res_q.hit_score) ? now_q - res_q.hit_score
		: res_q.hit_score - now_q;

	always_comb begin
		case (op_q)
			CMD_ADD:    do_write = res_q.key_hit || res_q.free_seen;
			CMD_REMOVE: do_write = res_q.key_hit;
			CMD_UPDATE: do_write = res_q.key_hit;
			default:    do_write = 1'b0;
		endcase
		wr           = '0;
		wr.en        = (state_q == S_FINISH) && out_free && do_write;
		wr.op        = op_q;
		wr.any_hit   = res_q.key_hit;
		wr.ua_en     = (op_q == CMD_ADD || op_q == CMD_REMOVE) && res_q.key_hit && res_q.hit_tp;
		wr.ua        = res_q.hit_tag;
		wr.ub_en     = (op_q == CMD_ADD) && req_q.tpres;
		wr.ub        = req_q.tag;
		wr.new_score = new_score_q;
	end

	// assemble the result for the current request
	always_comb begin
		out_data = '0;
		out_user = {1'b0, ST_OK};
		case (op_q)
			CMD_ADD: begin
				if (!do_write)
					out_user[1:0] = ST_FULL;
			end
			CMD_REMOVE, CMD_LKKEY: begin
				if (res_q.key_hit) begin
					out_data[127:64] = res_q.hit_tag;
					out_user[2]      = res_q.hit_tp;
				end else begin
					out_user[1:0] = ST_NOTFOUND;
				end
			end
			CMD_UPDATE: begin
				if (res_q.key_hit)
					out_data[175:128] = new_score_q;
				else
					out_user[1:0] = ST_NOTFOUND;
			end
			CMD_LKTAG: begin
				if (res_q.tag_found)
					out_data[63:0] = res_q.tag_key;
				else
					out_user[1:0] = ST_NOTFOUND;
			end
			CMD_LOWEST: begin
				if (res_q.min_valid)
					out_data[63:0] = res_q.min_key;
				else
					out_user[1:0] = ST_EMPTY;
			end
			CMD_TOTALS: begin
				out_data[227:176] = usum_q;
				out_data[279:228] = asum_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			start_q  <= 1'b0;
			m_tvalid <= 1'b0;
			usum_q   <= '0;
			asum_q   <= '0;
		end else begin
			start_q <= (state_q == S_IDLE) && s_tvalid;
			if (state_q == S_FINISH && out_free)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q        <= cmd_e_t'(s_tuser[2:0]);
						req_q.tpres <= s_tuser[3];
						req_q.key   <= s_tdata[63:0];
						req_q.tag   <= s_tdata[127:64];
						req_q.usage <= s_tdata[175:128];
						req_q.alloc <= s_tdata[223:176];
						req_q.score <= s_tdata[271:224];
						now_q       <= s_tdata[319:272];
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (chain[TABLE_DEPTH].pass) begin
						res_q   <= chain[TABLE_DEPTH];
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (op_q == CMD_UPDATE && res_q.key_hit) begin
						if (size == '0) begin
							amount_q <= AMOUNT_MIN;
							state_q  <= S_MUL;
						end else if (size > res_q.hit_usage ||
								{diff, 1'b0} >= {1'b0, size}) begin
							amount_q <= AMOUNT_MAX;
							state_q  <= S_MUL;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_DIV: begin
					if (div_done) begin
						amount_q <= (quo_amt < AMOUNT_MIN) ? AMOUNT_MIN : quo_amt;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					prod_s1 <= {16'd0, gap} * {48'd0, amount_q};
					up_s1   <= now_q >= res_q.hit_score;
					state_q <= S_ADJ;
				end
				S_ADJ: begin
					new_score_q <= up_s1 ? res_q.hit_score + prod_s1[63:16]
						: res_q.hit_score - prod_s1[63:16];
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						m_tdata <= out_data;
						m_tuser <= out_user;
						case (op_q)
							CMD_ADD: begin
								if (do_write) begin
									usum_q <= usum_q + SUM_W'(req_q.usage)
										- (res_q.key_hit ? SUM_W'(res_q.hit_usage) : '0);
									asum_q <= asum_q + SUM_W'(req_q.alloc)
										- (res_q.key_hit ? SUM_W'(res_q.hit_alloc) : '0);
								end
							end
							CMD_REMOVE: begin
								if (res_q.key_hit) begin
									usum_q <= usum_q - SUM_W'(res_q.hit_usage);
									asum_q <= asum_q - SUM_W'(res_q.hit_alloc);
								end
							end
							default: ;
						endcase
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV) else $error("divider finished outside S_DIV");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		chain[TABLE_DEPTH].pass |-> state_q == S_SCAN) else $error("scan ended outside S_SCAN");
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH |-> $onehot0(hit_vec)) else $error("key held by two cells");
	a_one_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH |-> $onehot0(free_vec)) else $error("two cells claim first free");
	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> state_q == S_IDLE) else $error("write not followed by idle");
`endif

endmodule
